// ----- rtl/fvmb_pkg.sv -----
// Shared types and constants for the future view message buffer.
// No dependencies; every other file in the project imports this package.
`default_nettype none
package fvmb_pkg;

   // Table geometry.
   localparam int SLOTS    = 16;
   localparam int REF_BITS = 16;

   // Fixed field widths on the ports.
   localparam int CMD_BITS    = 2;
   localparam int VIEW_BITS   = 64;
   localparam int MREF_BITS   = 16;
   localparam int STATUS_BITS = 3;
   localparam int OCC_BITS    = 5;
   localparam int WIN_BITS    = 8;

   localparam logic [WIN_BITS-1:0] WINDOW_RESET = 8'd8;

   // Commands.
   localparam logic [CMD_BITS-1:0] CMD_OFFER = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_PURGE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FETCH = 2'd2;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] ST_PASS     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_OUTWIN   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_STORED   = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_REPLACED = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_PURGED   = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_HIT      = 3'd6;
   localparam logic [STATUS_BITS-1:0] ST_MISS     = 3'd7;

   typedef struct packed {
      logic [CMD_BITS-1:0]  cmd;
      logic [VIEW_BITS-1:0] current_view;
      logic [VIEW_BITS-1:0] message_view;
      logic                 is_proposal;
      logic [MREF_BITS-1:0] message_ref;
   } fvmb_op_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [MREF_BITS-1:0]   fetched_ref;
      logic [OCC_BITS-1:0]    occupancy;
   } fvmb_result_type;

endpackage
`default_nettype wire

// ----- rtl/fvmb_table.sv -----
// View-keyed message table: all slots are compared in parallel, and the
// result of one operation is produced combinationally. Depends on fvmb_pkg.
`default_nettype none
module fvmb_table (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  enable,
   input  wire  [fvmb_pkg::WIN_BITS-1:0]        view_window,
   input  wire  fvmb_pkg::fvmb_op_type          op,
   output fvmb_pkg::fvmb_result_type            result
);
   import fvmb_pkg::*;

   logic [SLOTS-1:0]     valid_ff;
   logic [SLOTS-1:0]     valid_in;
   logic [VIEW_BITS-1:0] view_ff [SLOTS];
   logic [REF_BITS-1:0]  ref_ff  [SLOTS];

   logic [SLOTS-1:0]     hit_vec;
   logic [SLOTS-1:0]     old_vec;
   logic [SLOTS-1:0]     free_vec;
   logic [SLOTS-1:0]     free_first;
   logic [SLOTS-1:0]     view_we;
   logic [SLOTS-1:0]     ref_we;
   logic [VIEW_BITS-1:0] key;
   logic [REF_BITS-1:0]  hit_ref;
   logic [REF_BITS-1:0]  store_ref;
   logic [VIEW_BITS:0]   diff;
   logic                 out_of_window;

   // One comparator bank serves both the offer lookup and the fetch lookup.
   assign key       = (op.cmd == CMD_FETCH) ? op.current_view : op.message_view;
   assign store_ref = REF_BITS'(op.message_ref);
   assign free_vec  = ~valid_ff;
   assign free_first = free_vec & (~free_vec + SLOTS'(1));

   // The difference is taken at one extra bit, so the borrow shows a view
   // behind the current one and the window test never wraps.
   assign diff = {1'b0, op.message_view} - {1'b0, op.current_view};
   assign out_of_window = diff[VIEW_BITS] || (|diff[VIEW_BITS-1:WIN_BITS]) ||
                          (diff[WIN_BITS-1:0] > view_window);

   always_comb begin
      hit_ref = '0;
      for (int i = 0; i < SLOTS; i++) begin
         hit_vec[i] = valid_ff[i] && (view_ff[i] == key);
         old_vec[i] = valid_ff[i] && (view_ff[i] < op.current_view);
         if (hit_vec[i]) begin
            hit_ref = hit_ref | ref_ff[i];
         end
      end
   end

   always_comb begin
      valid_in           = valid_ff;
      view_we            = '0;
      ref_we             = '0;
      result.status      = ST_MISS;
      result.fetched_ref = '0;
      case (op.cmd)
         CMD_OFFER: begin
            if (op.message_view == op.current_view || !op.is_proposal) begin
               result.status = ST_PASS;
            end else if (out_of_window) begin
               result.status = ST_OUTWIN;
            end else if (|hit_vec) begin
               ref_we        = hit_vec;
               result.status = ST_REPLACED;
            end else if (|free_vec) begin
               valid_in      = valid_ff | free_first;
               view_we       = free_first;
               ref_we        = free_first;
               result.status = ST_STORED;
            end else begin
               result.status = ST_FULL;
            end
         end
         CMD_PURGE: begin
            valid_in      = valid_ff & ~old_vec;
            result.status = ST_PURGED;
         end
         CMD_FETCH: begin
            if (|hit_vec) begin
               valid_in           = valid_ff & ~hit_vec;
               result.fetched_ref = MREF_BITS'(hit_ref);
               result.status      = ST_HIT;
            end
         end
         default: begin
            result.status = ST_MISS;
         end
      endcase
      result.occupancy = OCC_BITS'($countones(valid_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (enable && view_we[i]) begin
            view_ff[i] <= op.message_view;
         end
         if (enable && ref_we[i]) begin
            ref_ff[i] <= store_ref;
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/future_view_message_buffer.sv -----
// Top level of the future view message buffer: input register, view table
// and result register. Depends on fvmb_pkg and fvmb_table.
//
//   channel | ports                  | direction | handshake
//   req     | req_cmd .. message_ref | in        | req_valid / req_ready
//   rsp     | status, ref, occupancy | out       | rsp_valid / rsp_ready
//   csr     | csr_write_data         | in        | csr_write_enable, no wait
//
// One beat is taken per cycle while the result register is free or drains.
// A beat is held in the input register, then the table lookup and update run
// in one pass into the result register. The table's parallel compare over all
// slots sets the cycle. When rsp_ready is low the result register holds and
// one more beat waits in the input register. Reset clears the valid flags,
// including those of the table slots, and loads the window with 8; stored
// views and handles are not cleared.
`default_nettype none
module future_view_message_buffer (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  [fvmb_pkg::CMD_BITS-1:0]     req_cmd,
   input  wire  [fvmb_pkg::VIEW_BITS-1:0]    req_current_view,
   input  wire  [fvmb_pkg::VIEW_BITS-1:0]    req_message_view,
   input  wire                               req_is_proposal,
   input  wire  [fvmb_pkg::MREF_BITS-1:0]    req_message_ref,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [fvmb_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [fvmb_pkg::MREF_BITS-1:0]    rsp_fetched_ref,
   output logic [fvmb_pkg::OCC_BITS-1:0]     rsp_occupancy,
   input  wire                               csr_write_enable,
   input  wire  [fvmb_pkg::WIN_BITS-1:0]     csr_write_data
);
   import fvmb_pkg::*;

   logic              in_valid_ff;
   fvmb_op_type       in_op_ff;
   logic              rsp_valid_ff;
   fvmb_result_type   rsp_res_ff;
   fvmb_result_type   table_res;
   logic [WIN_BITS-1:0] window_ff;
   logic              advance;

   // The held beat moves on whenever the result register is free or drains.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_write_enable) begin
         window_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_op_ff.cmd          <= req_cmd;
         in_op_ff.current_view <= req_current_view;
         in_op_ff.message_view <= req_message_view;
         in_op_ff.is_proposal  <= req_is_proposal;
         in_op_ff.message_ref  <= req_message_ref;
      end
   end

   fvmb_table u_table (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .view_window (window_ff),
      .op          (in_op_ff),
      .result      (table_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_res_ff <= table_res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_res_ff.status;
   assign rsp_fetched_ref = rsp_res_ff.fetched_ref;
   assign rsp_occupancy   = rsp_res_ff.occupancy;

endmodule
`default_nettype wire
